>>> sv/rau_pkg.sv
package rau_pkg;

    typedef logic [2:0] req_t;

    localparam req_t REQ_ADD = 3'd0;
    localparam req_t REQ_SUB = 3'd1;
    localparam req_t REQ_MUL = 3'd2;
    localparam req_t REQ_DIV = 3'd3;
    localparam req_t REQ_EQ  = 3'd4;

    // Status of the shared divider as seen by the sequencer.
    typedef struct packed {
        logic done;
        logic rem_zero;
    } rau_div_stat_t;

endpackage

>>> sv/rational_arithmetic_unit_top.sv
// Rational fraction unit: add, subtract, multiply, divide or compare two
// signed fractions, with the result reduced by a truncating Euclid gcd.
// Input channel: in_valid/in_ready with req_type, a_num, a_den, b_num, b_den.
// Output channel: out_valid/out_ready with res_num, res_den, is_equal and
// zero_gcd_error. One result item follows every input item.
// One item is processed at a time; in_ready is high only while idle.
// Steps: products on the shared WIDTH x WIDTH multiplier, then the unreduced
// parts are formed. Each Euclid remainder step is issued to the bit-serial
// divider, and the two final quotients also come from that divider, with
// NW = 2*WIDTH+1. A zero unreduced denominator skips the remainder steps.
// A zero-gcd error skips the final quotients, an equality test goes to the
// output after the products, and an unused request code goes straight there.
// The result is held in an output register until out_ready is seen, and
// no new item is taken while it waits.
// Reset clears the sequencer and the divider; the block comes up idle.
module rational_arithmetic_unit_top #(
    parameter int WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  rau_pkg::req_t             req_type,
    input  logic signed [WIDTH-1:0]   a_num,
    input  logic signed [WIDTH-1:0]   a_den,
    input  logic signed [WIDTH-1:0]   b_num,
    input  logic signed [WIDTH-1:0]   b_den,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [2*WIDTH:0]   res_num,
    output logic signed [2*WIDTH-1:0] res_den,
    output logic                      is_equal,
    output logic                      zero_gcd_error
);
    import rau_pkg::*;

    localparam int NW = 2 * WIDTH + 1;
    localparam int PW = 2 * WIDTH;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL0  = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_MUL2  = 4'd3;
    localparam logic [3:0] S_FORM  = 4'd4;
    localparam logic [3:0] S_GCD   = 4'd5;
    localparam logic [3:0] S_GWAIT = 4'd6;
    localparam logic [3:0] S_QN    = 4'd7;
    localparam logic [3:0] S_QD    = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] state_reg, state_next;

    req_t                  op_reg, op_next;
    logic signed [WIDTH-1:0] an_reg, an_next, ad_reg, ad_next;
    logic signed [WIDTH-1:0] bn_reg, bn_next, bd_reg, bd_next;
    logic signed [PW-1:0]  p_reg, p_next, q_reg, q_next;
    logic signed [NW-1:0]  n_reg, n_next, d_reg, d_next;
    logic signed [NW-1:0]  m_reg, m_next, b_reg, b_next, g_reg, g_next;
    logic signed [NW-1:0]  rn_reg, rn_next;
    logic signed [PW-1:0]  rd_reg, rd_next;
    logic                  eq_reg, eq_next, err_reg, err_next;

    logic signed [WIDTH-1:0] mul_a, mul_b;
    logic signed [PW-1:0]    product;
    logic signed [NW-1:0]    n_form;

    logic                  div_start;
    logic signed [NW-1:0]  div_a, div_b;
    logic signed [NW-1:0]  div_quo, div_rem;
    rau_div_stat_t         div_stat;

    rau_div #(
        .NW(NW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .quotient  (div_quo),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    // Shared multiplier; the operand pair depends on the step and the request.
    always_comb
    begin
        unique case (state_reg)
            S_MUL0:
            begin
                mul_a = an_reg;
                mul_b = (op_reg == REQ_MUL) ? bn_reg : bd_reg;
            end
            S_MUL1:
            begin
                mul_a = bn_reg;
                mul_b = ad_reg;
            end
            default:
            begin
                mul_a = ad_reg;
                mul_b = (op_reg == REQ_DIV) ? bn_reg : bd_reg;
            end
        endcase
    end

    assign product = PW'(mul_a) * PW'(mul_b);

    always_comb
    begin
        unique case (op_reg)
            REQ_ADD: n_form = NW'(p_reg) + NW'(q_reg);
            REQ_SUB: n_form = NW'(p_reg) - NW'(q_reg);
            default: n_form = NW'(p_reg);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        an_next    = an_reg;
        ad_next    = ad_reg;
        bn_next    = bn_reg;
        bd_next    = bd_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        m_next     = m_reg;
        b_next     = b_reg;
        g_next     = g_reg;
        rn_next    = rn_reg;
        rd_next    = rd_reg;
        eq_next    = eq_reg;
        err_next   = err_reg;
        div_start  = 1'b0;
        div_a      = n_reg;
        div_b      = m_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = req_type;
                    an_next  = a_num;
                    ad_next  = a_den;
                    bn_next  = b_num;
                    bd_next  = b_den;
                    rn_next  = '0;
                    rd_next  = '0;
                    eq_next  = 1'b0;
                    err_next = 1'b0;
                    if (req_type > REQ_EQ)
                        state_next = S_OUT;
                    else
                        state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                p_next     = product;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                q_next     = product;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                d_next     = NW'(product);
                state_next = S_FORM;
            end
            S_FORM:
            begin
                if (op_reg == REQ_EQ)
                begin
                    eq_next    = (p_reg == q_reg);
                    state_next = S_OUT;
                end
                else
                begin
                    n_next     = n_form;
                    m_next     = n_form;
                    b_next     = d_reg;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (b_reg == '0)
                begin
                    g_next = m_reg;
                    if (m_reg == '0)
                    begin
                        err_next   = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_a      = n_reg;
                        div_b      = m_reg;
                        state_next = S_QN;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    div_a      = m_reg;
                    div_b      = b_reg;
                    state_next = S_GWAIT;
                end
            end
            S_GWAIT:
            begin
                if (div_stat.done)
                begin
                    m_next = b_reg;
                    b_next = div_rem;
                    // A zero remainder ends the loop with the current divisor as gcd.
                    if (div_stat.rem_zero)
                    begin
                        g_next     = b_reg;
                        div_start  = 1'b1;
                        div_a      = n_reg;
                        div_b      = b_reg;
                        state_next = S_QN;
                    end
                    else
                        state_next = S_GCD;
                end
            end
            S_QN:
            begin
                if (div_stat.done)
                begin
                    rn_next    = div_quo;
                    div_start  = 1'b1;
                    div_a      = d_reg;
                    div_b      = g_reg;
                    state_next = S_QD;
                end
            end
            S_QD:
            begin
                if (div_stat.done)
                begin
                    rd_next    = div_quo[PW-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        an_reg  <= an_next;
        ad_reg  <= ad_next;
        bn_reg  <= bn_next;
        bd_reg  <= bd_next;
        p_reg   <= p_next;
        q_reg   <= q_next;
        n_reg   <= n_next;
        d_reg   <= d_next;
        m_reg   <= m_next;
        b_reg   <= b_next;
        g_reg   <= g_next;
        rn_reg  <= rn_next;
        rd_reg  <= rd_next;
        eq_reg  <= eq_next;
        err_reg <= err_next;
    end

    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = (state_reg == S_OUT);
    assign res_num        = rn_reg;
    assign res_den        = rd_reg;
    assign is_equal       = eq_reg;
    assign zero_gcd_error = err_reg;

endmodule

>>> sv/rau_div.sv
module rau_div #(
    parameter int NW = 33
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [NW-1:0]  dividend,
    input  logic signed [NW-1:0]  divisor,
    output logic signed [NW-1:0]  quotient,
    output logic signed [NW-1:0]  remainder,
    output rau_pkg::rau_div_stat_t stat
);
    import rau_pkg::*;

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] quo_reg, quo_next;
    logic [NW-1:0] dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic          quo_neg_reg, quo_neg_next;
    logic          rem_neg_reg, rem_neg_next;

    logic [NW:0]   shifted;
    logic [NW:0]   diff;
    logic [NW-1:0] dividend_mag;
    logic [NW-1:0] divisor_mag;

    assign dividend_mag = dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
    assign divisor_mag  = divisor[NW-1]  ? NW'(-divisor)  : NW'(divisor);

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        dvs_next     = dvs_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        quo_neg_next = quo_neg_reg;
        rem_neg_next = rem_neg_reg;
        if (start)
        begin
            rem_next     = '0;
            quo_next     = dividend_mag;
            dvs_next     = divisor_mag;
            cnt_next     = CW'(NW);
            busy_next    = 1'b1;
            quo_neg_next = dividend[NW-1] ^ divisor[NW-1];
            rem_neg_next = dividend[NW-1];
        end
        else if (busy_reg)
        begin
            // Restoring step: keep the trial difference when it does not borrow.
            if (!diff[NW])
            begin
                rem_next = diff[NW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[NW-1:0];
                quo_next = {quo_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dvs_reg     <= dvs_next;
        quo_neg_reg <= quo_neg_next;
        rem_neg_reg <= rem_neg_next;
    end

    assign quotient      = quo_neg_reg ? $signed(NW'(-quo_reg)) : $signed(quo_reg);
    assign remainder     = rem_neg_reg ? $signed(NW'(-rem_reg)) : $signed(rem_reg);
    assign stat.done     = done_reg;
    assign stat.rem_zero = (rem_reg == '0);

endmodule

>>> tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rau_pkg::*;

    localparam int WIDTH = 16;
    localparam int NUM_W = 2 * WIDTH + 1;
    localparam int DEN_W = 2 * WIDTH;
    localparam int CLK_PERIOD = 20;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int HOLD_AT_RESULT = 150;
    localparam int HOLD_CYCLES = 3000;
    localparam int DRAIN_CYCLES = 2000;
    localparam longint LIMIT_CYCLES = 4_000_000;
    localparam longint INT64_MAX = 64'sh7fff_ffff_ffff_ffff;

    // Request codes the block does not define; each still yields one all-zero item.
    localparam req_t REQ_RSVD5 = 3'd5;
    localparam req_t REQ_RSVD6 = 3'd6;
    localparam req_t REQ_RSVD7 = 3'd7;

    typedef logic signed [WIDTH-1:0] operand_t;

    localparam operand_t MOST_NEG = 16'sh8000;
    localparam operand_t MOST_POS = 16'sh7fff;

    typedef struct packed {
        logic signed [NUM_W-1:0] num;
        logic signed [DEN_W-1:0] den;
        logic                    eq;
        logic                    zerr;
    } fraction_result_t;

    typedef struct packed {
        req_t             op;
        operand_t         an;
        operand_t         ad;
        operand_t         bn;
        operand_t         bd;
        logic             typed;
        fraction_result_t want;
    } directed_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    req_t                    req_type = REQ_ADD;
    operand_t                a_num = '0;
    operand_t                a_den = '0;
    operand_t                b_num = '0;
    operand_t                b_den = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [NUM_W-1:0] res_num;
    logic signed [DEN_W-1:0] res_den;
    logic                    is_equal;
    logic                    zero_gcd_error;

    fraction_result_t pending_fractions[$];
    int               mismatches = 0;
    int               results_seen = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    directed_row_t    directed_rows[25];

    rational_arithmetic_unit_top #(
        .WIDTH(WIDTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .req_type       (req_type),
        .a_num          (a_num),
        .a_den          (a_den),
        .b_num          (b_num),
        .b_den          (b_den),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .res_num        (res_num),
        .res_den        (res_den),
        .is_equal       (is_equal),
        .zero_gcd_error (zero_gcd_error)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Euclid with a remainder that truncates toward zero, so the gcd may come out negative.
    function automatic longint trunc_euclid_gcd(longint m, longint n);
        longint r;
        while (n != 0)
        begin
            r = m % n;
            m = n;
            n = r;
        end
        return m;
    endfunction

    function automatic fraction_result_t predict_fraction(req_t op, operand_t an, operand_t ad,
                                                          operand_t bn, operand_t bd);
        fraction_result_t r;
        longint           xan, xad, xbn, xbd;
        longint           p, q, n, d, g, qn, qd;
        r = '0;
        xan = an;
        xad = ad;
        xbn = bn;
        xbd = bd;
        n = 0;
        d = 0;
        if (op == REQ_EQ)
        begin
            r.eq = (xan * xbd == xbn * xad);
            return r;
        end
        if (op > REQ_EQ)
            return r;
        case (op)
            REQ_ADD:
            begin
                p = xan * xbd;
                q = xbn * xad;
                // With 16-bit operands each product is at most 2**30, so the sum never leaves 64 bits.
                if (p > 0 && q > INT64_MAX - p)
                begin
                    r.num = 2;
                    r.den = 1;
                    return r;
                end
                n = p + q;
                d = xad * xbd;
            end
            REQ_SUB:
            begin
                n = xan * xbd - xbn * xad;
                d = xad * xbd;
            end
            REQ_MUL:
            begin
                n = xan * xbn;
                d = xad * xbd;
            end
            default:
            begin
                n = xan * xbd;
                d = xad * xbn;
            end
        endcase
        g = trunc_euclid_gcd(n, d);
        if (g == 0)
        begin
            r.zerr = 1'b1;
            return r;
        end
        qn = n / g;
        qd = d / g;
        r.num = qn[NUM_W-1:0];
        r.den = qd[DEN_W-1:0];
        return r;
    endfunction

    // Called at the edge where the previous item went in; one write to in_valid per edge.
    task automatic offer_request(req_t op, operand_t an, operand_t ad, operand_t bn,
                                 operand_t bd, fraction_result_t want);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        req_type <= op;
        a_num <= an;
        a_den <= ad;
        b_num <= bn;
        b_den <= bd;
        do
            @(posedge clk);
        while (!in_ready);
        pending_fractions.push_back(want);
    endtask

    function automatic operand_t random_operand();
        case ($urandom_range(9))
            0, 1, 2, 3: return operand_t'($urandom);
            4, 5, 6:    return operand_t'(int'($urandom_range(40)) - 20);
            7:          return '0;
            default:
            begin
                case ($urandom_range(3))
                    0:       return MOST_NEG;
                    1:       return MOST_POS;
                    2:       return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
        endcase
    endfunction

    task automatic offer_random_request();
        req_t     op;
        operand_t an, ad, bn, bd;
        int       k;
        if ($urandom_range(15) == 0)
            op = req_t'($urandom_range(REQ_RSVD7, REQ_RSVD5));
        else
            op = req_t'($urandom_range(REQ_EQ, REQ_ADD));
        an = random_operand();
        ad = random_operand();
        bn = random_operand();
        bd = random_operand();
        // Scaled copies give equal fractions and large common factors to cancel.
        if ($urandom_range(3) == 0)
        begin
            an = operand_t'(int'($urandom_range(40)) - 20);
            ad = operand_t'(int'($urandom_range(40)) - 20);
            k = $urandom_range(1, 9);
            if ($urandom_range(1) == 0)
                k = -k;
            bn = operand_t'(int'(an) * k);
            bd = operand_t'(int'(ad) * k);
        end
        offer_request(op, an, ad, bn, bd, predict_fraction(op, an, ad, bn, bd));
    endtask

    initial
    begin
        directed_rows = '{
            '{REQ_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b1, '{33'sd5, 32'sd6, 1'b0, 1'b0}},
            '{REQ_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2, 1'b1, '{33'sd0, 32'sd1, 1'b0, 1'b0}},
            '{REQ_MUL, 16'sd2, 16'sd3, 16'sd3, 16'sd4, 1'b1, '{33'sd1, 32'sd2, 1'b0, 1'b0}},
            '{REQ_DIV, 16'sd1, 16'sd2, 16'sd1, 16'sd4, 1'b1, '{33'sd2, 32'sd1, 1'b0, 1'b0}},
            '{REQ_EQ, 16'sd1, 16'sd2, 16'sd2, 16'sd4, 1'b1, '{33'sd0, 32'sd0, 1'b1, 1'b0}},
            '{REQ_EQ, 16'sd1, 16'sd2, 16'sd1, 16'sd3, 1'b1, '{33'sd0, 32'sd0, 1'b0, 1'b0}},
            '{REQ_MUL, 16'sd0, 16'sd0, 16'sd5, 16'sd7, 1'b1, '{33'sd0, 32'sd0, 1'b0, 1'b1}},
            '{REQ_DIV, 16'sd0, 16'sd3, 16'sd0, 16'sd5, 1'b1, '{33'sd0, 32'sd0, 1'b0, 1'b1}},
            '{REQ_ADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, '{33'sd0, 32'sd0, 1'b0, 1'b1}},
            '{REQ_RSVD5, MOST_POS, MOST_NEG, -16'sd1, 16'sd1, 1'b1, '0},
            '{REQ_RSVD6, MOST_NEG, MOST_POS, 16'sd1, -16'sd1, 1'b1, '0},
            '{REQ_RSVD7, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b1, '0},
            '{REQ_MUL, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, 1'b1,
              '{33'sd1, 32'sd1, 1'b0, 1'b0}},
            '{REQ_ADD, MOST_NEG, 16'sd1, MOST_NEG, 16'sd1, 1'b1,
              '{-33'sd65536, 32'sd1, 1'b0, 1'b0}},
            '{REQ_MUL, MOST_POS, 16'sd1, MOST_POS, -16'sd1, 1'b0, '0},
            '{REQ_SUB, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, 1'b0, '0},
            '{REQ_ADD, MOST_POS, MOST_NEG, MOST_NEG, MOST_POS, 1'b0, '0},
            '{REQ_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd5, 1'b1, '{33'sd1, 32'sd0, 1'b0, 1'b0}},
            '{REQ_SUB, 16'sd3, -16'sd4, 16'sd5, 16'sd6, 1'b0, '0},
            '{REQ_EQ, -16'sd1, 16'sd2, 16'sd1, -16'sd2, 1'b1, '{33'sd0, 32'sd0, 1'b1, 1'b0}},
            '{REQ_EQ, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS, 1'b1,
              '{33'sd0, 32'sd0, 1'b1, 1'b0}},
            '{REQ_DIV, MOST_NEG, MOST_POS, MOST_POS, MOST_NEG, 1'b0, '0},
            '{REQ_ADD, 16'sd0, 16'sd5, 16'sd0, 16'sd7, 1'b1, '{33'sd0, 32'sd1, 1'b0, 1'b0}},
            '{REQ_MUL, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 1'b1,
              '{33'sd1, 32'sd1, 1'b0, 1'b0}},
            '{REQ_SUB, MOST_POS, MOST_POS, MOST_NEG, MOST_NEG, 1'b0, '0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            offer_request(directed_rows[i].op, directed_rows[i].an, directed_rows[i].ad,
                          directed_rows[i].bn, directed_rows[i].bd,
                          directed_rows[i].typed ? directed_rows[i].want :
                          predict_fraction(directed_rows[i].op, directed_rows[i].an,
                                           directed_rows[i].ad, directed_rows[i].bn,
                                           directed_rows[i].bd));
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 83;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 83;
                end
                default:
                begin
                    send_idle_pct = 28;
                    recv_stall_pct = 28;
                end
            endcase
            repeat (ITEMS_PER_PHASE) offer_random_request();
        end

        in_valid <= 1'b0;
        while (pending_fractions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: check each accepted item, then pick out_ready for the next edge.
    initial
    begin
        fraction_result_t want;
        int               hold_left;
        bit               hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready)
            begin
                results_seen++;
                if (pending_fractions.size() == 0)
                begin
                    $error("result item with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_fractions.pop_front();
                    if (res_num !== want.num)
                    begin
                        $error("res_num: expected %0d, got %0d", want.num, res_num);
                        mismatches++;
                    end
                    if (res_den !== want.den)
                    begin
                        $error("res_den: expected %0d, got %0d", want.den, res_den);
                        mismatches++;
                    end
                    if (is_equal !== want.eq)
                    begin
                        $error("is_equal: expected %0b, got %0b", want.eq, is_equal);
                        mismatches++;
                    end
                    if (zero_gcd_error !== want.zerr)
                    begin
                        $error("zero_gcd_error: expected %0b, got %0b", want.zerr,
                               zero_gcd_error);
                        mismatches++;
                    end
                end
            end
            // One long hold-off lets the output register fill while requests keep coming.
            if (!hold_done && results_seen == HOLD_AT_RESULT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
